// File: sv/tlp_pkg.sv
package tlp_pkg;

    // Widths fixed by the line format.
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 2;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_DATA_W = 16;

    localparam int MAX_LITERALS_DEF = 64;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_FIRST_IN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IN        = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FIRST_OUT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_OUT       = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ERROR     = 3'd5;

    // Literal values.
    localparam logic [VALUE_W-1:0] LIT_FALSE = 2'd0;
    localparam logic [VALUE_W-1:0] LIT_TRUE  = 2'd1;
    localparam logic [VALUE_W-1:0] LIT_DC    = 2'd2;

    // Line status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_INPUTS  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_OUTPUTS = 1'd1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UP_T  = 8'h54;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    typedef struct packed {
        logic               is_lit;
        logic [VALUE_W-1:0] lit_value;
        logic               is_blank;
        logic               is_gt;
        logic               is_term;
    } char_class_t;

    typedef struct packed {
        logic                lit_valid;
        logic                lit_side;
        logic [VALUE_W-1:0]  lit_value;
        logic [POS_W-1:0]    lit_pos;
        logic                done;
        logic [STATUS_W-1:0] status;
    } parse_result_t;

endpackage

// File: sv/tlp_classify.sv
module tlp_classify (
    input  logic [tlp_pkg::CHAR_W-1:0] char_code,
    output tlp_pkg::char_class_t       cls
);
    import tlp_pkg::*;

    always_comb
    begin
        cls = '0;
        case (char_code)
            CH_UP_T, CH_LO_T:
            begin
                cls.is_lit    = 1'b1;
                cls.lit_value = LIT_TRUE;
            end
            CH_UP_F, CH_LO_F:
            begin
                cls.is_lit    = 1'b1;
                cls.lit_value = LIT_FALSE;
            end
            CH_UP_X, CH_LO_X, CH_DASH:
            begin
                cls.is_lit    = 1'b1;
                cls.lit_value = LIT_DC;
            end
            CH_SPACE, CH_TAB:
            begin
                cls.is_blank = 1'b1;
            end
            CH_GT:
            begin
                cls.is_gt = 1'b1;
            end
            CH_LF, CH_NUL, CH_CR, CH_FF, CH_SEMI:
            begin
                cls.is_term = 1'b1;
            end
            default:
            begin
                cls = '0;
            end
        endcase
    end

endmodule

// File: sv/tlp_parse.sv
module tlp_parse #(
    parameter int MAX_LITERALS = tlp_pkg::MAX_LITERALS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  tlp_pkg::char_class_t        cls,
    input  logic                        line_end,
    input  logic [tlp_pkg::COUNT_W-1:0] exp_inputs,
    input  logic [tlp_pkg::COUNT_W-1:0] exp_outputs,
    output tlp_pkg::parse_result_t      result
);
    import tlp_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LITERALS);

    logic [PHASE_W-1:0] phase_reg, phase_next, phase_mid;
    logic [COUNT_W-1:0] in_cnt_reg, in_cnt_next, in_cnt_mid;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next, out_cnt_mid;
    logic               out_side;
    logic [COUNT_W-1:0] cnt_sel;

    assign out_side = phase_reg[1];
    assign cnt_sel  = out_side ? out_cnt_reg : in_cnt_reg;

    always_comb
    begin
        phase_mid   = phase_reg;
        in_cnt_mid  = in_cnt_reg;
        out_cnt_mid = out_cnt_reg;
        result      = '0;

        // Phases above the output side take no part in parsing.
        if (!phase_reg[2])
        begin
            if (cls.is_lit)
            begin
                if (cnt_sel >= MAX_COUNT)
                begin
                    phase_mid = PH_ERROR;
                end
                else
                begin
                    result.lit_valid = 1'b1;
                    result.lit_side  = out_side;
                    result.lit_value = cls.lit_value;
                    result.lit_pos   = cnt_sel[POS_W-1:0];
                    if (out_side)
                    begin
                        out_cnt_mid = out_cnt_reg + COUNT_W'(1);
                        phase_mid   = PH_OUT;
                    end
                    else
                    begin
                        in_cnt_mid = in_cnt_reg + COUNT_W'(1);
                        phase_mid  = PH_IN;
                    end
                end
            end
            else if (cls.is_blank)
            begin
                phase_mid = phase_reg;
            end
            else if (phase_reg == PH_IN && cls.is_gt)
            begin
                phase_mid = PH_FIRST_OUT;
            end
            else if (phase_reg == PH_OUT && cls.is_term)
            begin
                phase_mid = PH_DONE;
            end
            else
            begin
                phase_mid = PH_ERROR;
            end
        end

        phase_next   = phase_mid;
        in_cnt_next  = in_cnt_mid;
        out_cnt_next = out_cnt_mid;

        if (line_end)
        begin
            result.done = 1'b1;
            if (phase_mid == PH_DONE)
            begin
                result.status = (in_cnt_mid == exp_inputs && out_cnt_mid == exp_outputs)
                                ? ST_ACCEPTED : ST_ERROR;
            end
            else if (!phase_mid[2])
            begin
                result.status = ST_INCOMPLETE;
            end
            else
            begin
                result.status = ST_ERROR;
            end
            phase_next   = PH_FIRST_IN;
            in_cnt_next  = '0;
            out_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST_IN;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

endmodule

// File: sv/truth_table_line_parser_core.sv
// Channel   Direction  Payload
// s_axis    in         tdata = char_code[7:0], tlast = line_end
// m_axis    out        tdata = literal fields and status, tlast = line_done
// cfg       in         cfg_we, cfg_addr selects expected_inputs/outputs, cfg_wdata
//
// One character word is accepted per cycle while m_axis is not stalled; each word
// yields one result word through the input register, then the result register.
// The parse state update steps the phase and counters together.
// Reset clears the parse state, the valid flags and restores both expected counts to 1.
// A stall on m_axis holds the result register; one more word can wait in the input
// register before s_tready drops.
module truth_table_line_parser_core #(
    parameter int MAX_LITERALS = tlp_pkg::MAX_LITERALS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tlp_pkg::CHAR_W-1:0]       s_tdata,   // [7:0] char_code
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] literal_valid, [1] literal_side, [3:2] literal_value,
    // [9:4] literal_position, [11:10] line_status, [15:12] zero
    output logic [tlp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [tlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tlp_pkg::COUNT_W-1:0]      cfg_wdata
);
    import tlp_pkg::*;

    logic [COUNT_W-1:0] exp_in_reg, exp_out_reg;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    parse_result_t     out_res_reg;

    logic              out_adv;
    logic              in_adv;
    char_class_t       cls;
    parse_result_t     res;

    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_in_reg  <= COUNT_W'(1);
            exp_out_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_EXP_INPUTS:  exp_in_reg  <= cfg_wdata;
                REG_EXP_OUTPUTS: exp_out_reg <= cfg_wdata;
                default:         exp_in_reg  <= exp_in_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tlp_classify u_classify (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    tlp_parse #(
        .MAX_LITERALS (MAX_LITERALS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_adv),
        .cls         (cls),
        .line_end    (in_last_reg),
        .exp_inputs  (exp_in_reg),
        .exp_outputs (exp_out_reg),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.done;
    assign m_tdata  = {4'b0000, out_res_reg.status, out_res_reg.lit_pos,
                       out_res_reg.lit_value, out_res_reg.lit_side, out_res_reg.lit_valid};

endmodule
